// ----- rtl/core/avr_instruction_subset_execute_defines.svh -----
// Assertion macros shared by the execute block.
`ifndef AVR_INSTRUCTION_SUBSET_EXECUTE_DEFINES_SVH
`define AVR_INSTRUCTION_SUBSET_EXECUTE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define AVR_ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);
// Implication checked at the clock edge after the antecedent.
`define AVR_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);
`endif

// ----- rtl/core/avrx_pkg.sv -----
`default_nettype none
package avrx_pkg;
    typedef enum logic [1:0] {
        RUN_CONTINUE = 2'd0,
        RUN_SLEEP    = 2'd1,
        RUN_BREAK    = 2'd2,
        RUN_UNDEF    = 2'd3
    } run_status_t;

    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_V = 3;
    localparam int unsigned FLAG_S = 4;
    localparam int unsigned FLAG_H = 5;
    localparam int unsigned FLAG_T = 6;

    localparam logic [15:0] SP_RESET    = 16'hFFFF;
    localparam logic [15:0] IO_BASE     = 16'h0020;
    localparam logic [15:0] OP_SLEEP    = 16'h9588;
    localparam logic [15:0] OP_BREAK    = 16'h9598;

    // Architectural state update produced by the execute logic.
    typedef struct packed {
        logic        rd_we;
        logic [4:0]  rd_addr;
        logic [7:0]  rd_data;
        logic        rd2_we;
        logic [4:0]  rd2_addr;
        logic [7:0]  rd2_data;
        logic [7:0]  sreg;
        logic        sp_dec;
    } avrx_upd_t;

    // Result word fields excluding the program counter, flags and cycle total.
    typedef struct packed {
        run_status_t run_status;
        logic [2:0]  cycles;
        logic [1:0]  wr_count;
        logic [15:0] wr_addr;
        logic [7:0]  wr_d1;
        logic [7:0]  wr_d2;
    } avrx_res_t;
endpackage
`default_nettype wire

// ----- rtl/core/avrx_alu.sv -----
`default_nettype none
module avrx_alu #(
    parameter int unsigned PC_BITS = 16
) (
    input  wire logic [15:0]        instr,
    input  wire logic [15:0]        next_word,
    input  wire logic [PC_BITS-1:0] pc,
    input  wire logic [15:0]        sp,
    input  wire logic [7:0]         sreg,
    input  wire logic [7:0]         rf [32],
    output avrx_pkg::avrx_upd_t     upd,
    output avrx_pkg::avrx_res_t     res,
    output logic [PC_BITS-1:0]      npc
);
    import avrx_pkg::*;

    logic [4:0]  d5, r5, dh, lo;
    logic [7:0]  k8, a, b, r;
    logic [2:0]  bitn;
    logic [8:0]  sum9;
    logic [4:0]  sumh;
    logic [15:0] pair, wres;
    logic [16:0] wsum;
    logic [5:0]  kw;
    logic [PC_BITS-1:0] pc1, pc2, bofs;
    logic [7:0]  s;
    logic        cin;

    always_comb begin
        d5   = instr[8:4];
        r5   = {instr[9], instr[3:0]};
        dh   = {1'b1, instr[7:4]};
        k8   = {instr[11:8], instr[3:0]};
        bitn = instr[2:0];
        lo   = {2'b11, instr[5:4], 1'b0};
        kw   = {instr[7:6], instr[3:0]};
        a    = rf[d5];
        b    = rf[r5];
        pc1  = pc + PC_BITS'(1);
        pc2  = pc + PC_BITS'(2);
        bofs = PC_BITS'($signed(instr[9:3]));
        pair = {rf[lo + 5'd1], rf[lo]};
        wsum = {1'b0, pair} + {11'd0, kw};
        wres = wsum[15:0];
        cin  = 1'b0;
        sum9 = '0;
        sumh = '0;
        r    = '0;
        s    = sreg;

        upd = '0;
        upd.sreg = sreg;
        upd.rd_addr = d5;
        res = '0;
        res.run_status = RUN_CONTINUE;
        res.cycles = 3'd1;
        npc = pc1;

        if (instr[15:10] == 6'b000111 || instr[15:10] == 6'b000011) begin
            cin  = instr[12] & sreg[FLAG_C];
            sum9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
            sumh = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
            r    = sum9[7:0];
            s[FLAG_C] = sum9[8];
            s[FLAG_H] = sumh[4];
            s[FLAG_V] = ~(a[7] ^ b[7]) & (a[7] ^ r[7]);
            s[FLAG_N] = r[7];
            s[FLAG_Z] = (r == 8'd0);
            s[FLAG_S] = s[FLAG_N] ^ s[FLAG_V];
            upd.sreg = s;
            upd.rd_we = 1'b1;
            upd.rd_data = r;
        end else if (instr[15:8] == 8'h96) begin
            s[FLAG_C] = wsum[16];
            s[FLAG_V] = ~pair[15] & wres[15];
            s[FLAG_N] = wres[15];
            s[FLAG_Z] = (wres == 16'd0);
            s[FLAG_S] = s[FLAG_N] ^ s[FLAG_V];
            upd.sreg = s;
            upd.rd_we = 1'b1;
            upd.rd_addr = lo;
            upd.rd_data = wres[7:0];
            upd.rd2_we = 1'b1;
            upd.rd2_addr = lo + 5'd1;
            upd.rd2_data = wres[15:8];
            res.cycles = 3'd2;
        end else if (instr[15:10] == 6'b001000 || instr[15:10] == 6'b001001
                     || instr[15:12] == 4'h7) begin
            if (instr[15:12] == 4'h7) begin
                r = rf[dh] & k8;
                upd.rd_addr = dh;
            end else if (instr[10]) begin
                r = a ^ b;
            end else begin
                r = a & b;
            end
            s[FLAG_V] = 1'b0;
            s[FLAG_N] = r[7];
            s[FLAG_Z] = (r == 8'd0);
            s[FLAG_S] = r[7];
            upd.sreg = s;
            upd.rd_we = 1'b1;
            upd.rd_data = r;
        end else if ((instr & 16'hFE0F) == 16'h9405) begin
            r = {a[7], a[7:1]};
            s[FLAG_C] = a[0];
            s[FLAG_N] = r[7];
            s[FLAG_V] = r[7] ^ a[0];
            s[FLAG_Z] = (r == 8'd0);
            s[FLAG_S] = a[0];
            upd.sreg = s;
            upd.rd_we = 1'b1;
            upd.rd_data = r;
        end else if ((instr & 16'hFF8F) == 16'h9488) begin
            s[instr[6:4]] = 1'b0;
            upd.sreg = s;
        end else if ((instr & 16'hFE08) == 16'hF800) begin
            r = a;
            r[bitn] = sreg[FLAG_T];
            upd.rd_we = 1'b1;
            upd.rd_data = r;
        end else if (instr[15:11] == 5'b11110) begin
            // Branch taken when the tested flag matches the wanted polarity.
            if (sreg[bitn] == ~instr[10]) begin
                npc = pc1 + bofs;
                res.cycles = 3'd2;
            end
        end else if ((instr & 16'hFF8F) == 16'h9408) begin
            s[instr[6:4]] = 1'b1;
            upd.sreg = s;
        end else if ((instr & 16'hFE08) == 16'hFA00) begin
            s[FLAG_T] = a[bitn];
            upd.sreg = s;
        end else if ((instr & 16'hFE0E) == 16'h940E) begin
            res.wr_count = 2'd2;
            res.wr_addr  = sp;
            res.wr_d1    = 8'(16'(pc2) >> 8);
            res.wr_d2    = 8'(pc2);
            upd.sp_dec   = 1'b1;
            npc = next_word[PC_BITS-1:0];
            res.cycles = 3'd4;
        end else if (instr[15:12] == 4'h3) begin
            a = rf[dh];
            r = a - k8;
            s[FLAG_C] = (a < k8);
            s[FLAG_H] = (a[3:0] < k8[3:0]);
            s[FLAG_V] = (a[7] ^ k8[7]) & (a[7] ^ r[7]);
            s[FLAG_N] = r[7];
            s[FLAG_Z] = (r == 8'd0);
            s[FLAG_S] = s[FLAG_N] ^ s[FLAG_V];
            upd.sreg = s;
        end else if ((instr & 16'hFE0F) == 16'h9403) begin
            r = a + 8'd1;
            s[FLAG_V] = (a == 8'h7F);
            s[FLAG_N] = r[7];
            s[FLAG_Z] = (r == 8'd0);
            s[FLAG_S] = s[FLAG_N] ^ s[FLAG_V];
            upd.sreg = s;
            upd.rd_we = 1'b1;
            upd.rd_data = r;
        end else if (instr[15:12] == 4'hE) begin
            upd.rd_we = 1'b1;
            upd.rd_addr = dh;
            upd.rd_data = k8;
        end else if (instr[15:11] == 5'b10111) begin
            res.wr_count = 2'd1;
            res.wr_addr  = {10'd0, instr[10:9], instr[3:0]} + IO_BASE;
            res.wr_d1    = a;
        end else if (instr == OP_SLEEP) begin
            res.run_status = RUN_SLEEP;
        end else if (instr == OP_BREAK) begin
            res.run_status = RUN_BREAK;
        end else begin
            res.run_status = RUN_UNDEF;
            res.cycles = 3'd0;
            npc = pc;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/avr_instruction_subset_execute.sv -----
// A word's result is registered at the edge that accepts it, so m_valid rises in
// the cycle after acceptance. Throughput: one instruction word per cycle unless
// m_ready is low with the result register full; the register file, status register
// and counters update at the accepting edge, so the next word sees them at once.
// Reset (aresetn low, synchronous) clears registers, status, PC, cycle total, sets SP
// to 0xFFFF and empties the result register.
`default_nettype none
`include "avr_instruction_subset_execute_defines.svh"
module avr_instruction_subset_execute #(
    parameter int unsigned PC_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_instr_word,
    input  wire logic [15:0] s_following_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_next_pc,
    output logic [1:0]       m_run_status,
    output logic [2:0]       m_cycles_taken,
    output logic [1:0]       m_mem_write_count,
    output logic [15:0]      m_mem_write_addr,
    output logic [7:0]       m_mem_write_first_data,
    output logic [7:0]       m_mem_write_second_data,
    output logic [7:0]       m_flags_out,
    output logic [31:0]      m_cycle_count
);
    import avrx_pkg::*;

    // Architectural state. The register file is 32 bytes in flip-flops; it is
    // read at several decoded places in one cycle by the execute logic.
    logic [7:0]         rf_reg [32];
    logic [7:0]         sreg_reg;
    logic [PC_BITS-1:0] pc_reg;
    logic [15:0]        sp_reg;
    logic [31:0]        total_reg;

    logic               out_valid_reg;
    logic [PC_BITS-1:0] out_pc_reg;
    avrx_res_t          out_res_reg;
    logic [7:0]         out_flags_reg;
    logic [31:0]        out_total_reg;

    avrx_upd_t          upd;
    avrx_res_t          res;
    logic [PC_BITS-1:0] npc;
    logic               accept;
    logic [31:0]        total_next;

    // The result register is free or is being drained this cycle.
    assign s_ready = ~out_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;
    assign total_next = total_reg + {29'd0, res.cycles};

    avrx_alu #(.PC_BITS(PC_BITS)) u_alu (
        .instr     (s_instr_word),
        .next_word (s_following_word),
        .pc        (pc_reg),
        .sp        (sp_reg),
        .sreg      (sreg_reg),
        .rf        (rf_reg),
        .upd       (upd),
        .res       (res),
        .npc       (npc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 32; i++) begin
                rf_reg[i] <= 8'd0;
            end
            sreg_reg      <= 8'd0;
            pc_reg        <= '0;
            sp_reg        <= SP_RESET;
            total_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (upd.rd_we) begin
                    rf_reg[upd.rd_addr] <= upd.rd_data;
                end
                if (upd.rd2_we) begin
                    rf_reg[upd.rd2_addr] <= upd.rd2_data;
                end
                sreg_reg  <= upd.sreg;
                pc_reg    <= npc;
                total_reg <= total_next;
                if (upd.sp_dec) begin
                    sp_reg <= sp_reg - 16'd2;
                end
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the result word needs no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_pc_reg    <= npc;
            out_res_reg   <= res;
            out_flags_reg <= upd.sreg;
            out_total_reg <= total_next;
        end
    end

    assign m_valid                 = out_valid_reg;
    assign m_next_pc               = 16'(out_pc_reg);
    assign m_run_status            = out_res_reg.run_status;
    assign m_cycles_taken          = out_res_reg.cycles;
    assign m_mem_write_count       = out_res_reg.wr_count;
    assign m_mem_write_addr        = out_res_reg.wr_addr;
    assign m_mem_write_first_data  = out_res_reg.wr_d1;
    assign m_mem_write_second_data = out_res_reg.wr_d2;
    assign m_flags_out             = out_flags_reg;
    assign m_cycle_count           = out_total_reg;

    // An undefined opcode leaves the program counter where it was.
    `AVR_ASSERT_NEXT(a_undef_pc, aclk, aresetn, accept && res.run_status == RUN_UNDEF, pc_reg == $past(pc_reg), "undefined opcode moved the PC")
    // The delivered total always matches the running total after acceptance.
    `AVR_ASSERT_NEXT(a_total, aclk, aresetn, accept, m_cycle_count == total_reg, "cycle total mismatch")
    // Only a CALL reports two memory writes, and it moves SP down by two.
    `AVR_ASSERT_NEXT(a_call_sp, aclk, aresetn, accept && res.wr_count == 2'd2, sp_reg == $past(sp_reg) - 16'd2, "CALL stack update wrong")
endmodule
`default_nettype wire

// ----- test/tb_avr_instruction_subset_execute.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Expected contents of one result word.
typedef struct {
    logic [15:0] next_pc;
    logic [1:0]  run_status;
    logic [2:0]  cycles;
    logic [1:0]  wr_count;
    logic [15:0] wr_addr;
    logic [7:0]  wr_d1;
    logic [7:0]  wr_d2;
    logic [7:0]  flags;
    logic [31:0] cycle_count;
} exec_result_t;

// Testbench for the AVR instruction subset executor.
// A scoreboard object keeps its own copy of the architectural state (register
// file, status register, PC, SP and cycle total). It computes the expected
// result word for every accepted instruction word and compares each returned
// result word with the oldest one waiting.
class avr_exec_scoreboard;
    logic [7:0]  gpr [32];
    logic [7:0]  sreg;
    logic [15:0] pc;
    logic [15:0] sp;
    logic [31:0] total;

    exec_result_t pending[$];
    int errors;
    int checked;

    function new();
        int i;
        for (i = 0; i < 32; i++) gpr[i] = 8'h00;
        sreg = 8'h00;
        pc = 16'h0000;
        sp = avrx_pkg::SP_RESET;
        total = 32'h0;
        errors = 0;
        checked = 0;
    endfunction

    // After clearing the given bits, sets V from v, N and Z from res, and derives S.
    function void logic_flags(logic [7:0] res, logic [7:0] clr, logic v);
        logic [7:0] s;
        s = sreg & ~clr;
        s[avrx_pkg::FLAG_V] = s[avrx_pkg::FLAG_V] | v;
        s[avrx_pkg::FLAG_N] = s[avrx_pkg::FLAG_N] | res[7];
        s[avrx_pkg::FLAG_Z] = s[avrx_pkg::FLAG_Z] | (res == 8'h00);
        s[avrx_pkg::FLAG_S] = s[avrx_pkg::FLAG_S] | (s[avrx_pkg::FLAG_N] ^ s[avrx_pkg::FLAG_V]);
        sreg = s;
    endfunction

    function logic [7:0] add_bytes(logic [7:0] a, logic [7:0] b, logic cin);
        logic [8:0] sum;
        logic [4:0] half;
        sum = a + b + cin;
        half = a[3:0] + b[3:0] + cin;
        logic_flags(sum[7:0], 8'h3F, (~(a[7] ^ b[7])) & (a[7] ^ sum[7]));
        sreg[avrx_pkg::FLAG_C] = sum[8];
        sreg[avrx_pkg::FLAG_H] = half[4];
        return sum[7:0];
    endfunction

    function void note_word(logic [15:0] w, logic [15:0] w2);
        exec_result_t e;
        logic [4:0]  d5, r5, dh, lo;
        logic [7:0]  k8, a, r;
        logic [2:0]  bsel;
        logic [15:0] npc, pair, wres, koff, ret;
        logic [16:0] wsum;
        d5 = w[8:4];
        dh = {1'b1, w[7:4]};
        r5 = {w[9], w[3:0]};
        k8 = {w[11:8], w[3:0]};
        bsel = w[2:0];
        npc = pc + 16'd1;
        e.run_status = avrx_pkg::RUN_CONTINUE;
        e.cycles = 3'd1;
        e.wr_count = 2'd0;
        e.wr_addr = 16'h0;
        e.wr_d1 = 8'h0;
        e.wr_d2 = 8'h0;
        if ((w & 16'hFC00) == 16'h1C00) begin
            gpr[d5] = add_bytes(gpr[d5], gpr[r5], sreg[avrx_pkg::FLAG_C]);
        end else if ((w & 16'hFC00) == 16'h0C00) begin
            gpr[d5] = add_bytes(gpr[d5], gpr[r5], 1'b0);
        end else if ((w & 16'hFF00) == 16'h9600) begin
            lo = 5'd24 + {w[5:4], 1'b0};
            pair = {gpr[lo + 5'd1], gpr[lo]};
            wsum = pair + {w[7:6], w[3:0]};
            wres = wsum[15:0];
            sreg = sreg & ~8'h1F;
            sreg[avrx_pkg::FLAG_C] = wsum[16];
            sreg[avrx_pkg::FLAG_V] = ~pair[15] & wres[15];
            sreg[avrx_pkg::FLAG_N] = wres[15];
            sreg[avrx_pkg::FLAG_Z] = (wres == 16'h0);
            sreg[avrx_pkg::FLAG_S] = sreg[avrx_pkg::FLAG_N] ^ sreg[avrx_pkg::FLAG_V];
            gpr[lo + 5'd1] = wres[15:8];
            gpr[lo] = wres[7:0];
            e.cycles = 3'd2;
        end else if ((w & 16'hFC00) == 16'h2000) begin
            r = gpr[d5] & gpr[r5];
            logic_flags(r, 8'h1E, 1'b0);
            gpr[d5] = r;
        end else if ((w & 16'hF000) == 16'h7000) begin
            r = gpr[dh] & k8;
            logic_flags(r, 8'h1E, 1'b0);
            gpr[dh] = r;
        end else if ((w & 16'hFE0F) == 16'h9405) begin
            a = gpr[d5];
            r = {a[7], a[7:1]};
            logic_flags(r, 8'h1F, a[7] ^ a[0]);
            sreg[avrx_pkg::FLAG_C] = a[0];
            gpr[d5] = r;
        end else if ((w & 16'hFF8F) == 16'h9488) begin
            sreg[w[6:4]] = 1'b0;
        end else if ((w & 16'hFE08) == 16'hF800) begin
            gpr[d5][bsel] = sreg[avrx_pkg::FLAG_T];
        end else if ((w & 16'hF800) == 16'hF000) begin
            // Branch on a status bit: set for BRBS, clear for BRBC.
            koff = {{9{w[9]}}, w[9:3]};
            if (sreg[bsel] == ~w[10]) begin
                npc = npc + koff;
                e.cycles = 3'd2;
            end
        end else if ((w & 16'hFF8F) == 16'h9408) begin
            sreg[w[6:4]] = 1'b1;
        end else if ((w & 16'hFE08) == 16'hFA00) begin
            sreg[avrx_pkg::FLAG_T] = gpr[d5][bsel];
        end else if ((w & 16'hFE0E) == 16'h940E) begin
            ret = pc + 16'd2;
            e.wr_count = 2'd2;
            e.wr_addr = sp;
            e.wr_d1 = ret[15:8];
            e.wr_d2 = ret[7:0];
            sp = sp - 16'd2;
            npc = w2;
            e.cycles = 3'd4;
        end else if ((w & 16'hF000) == 16'h3000) begin
            a = gpr[dh];
            r = a - k8;
            logic_flags(r, 8'h3F, (a[7] ^ k8[7]) & (a[7] ^ r[7]));
            sreg[avrx_pkg::FLAG_C] = a < k8;
            sreg[avrx_pkg::FLAG_H] = a[3:0] < k8[3:0];
        end else if ((w & 16'hFC00) == 16'h2400) begin
            r = gpr[d5] ^ gpr[r5];
            logic_flags(r, 8'h1E, 1'b0);
            gpr[d5] = r;
        end else if ((w & 16'hFE0F) == 16'h9403) begin
            a = gpr[d5];
            r = a + 8'd1;
            logic_flags(r, 8'h1E, a == 8'h7F);
            gpr[d5] = r;
        end else if ((w & 16'hF000) == 16'hE000) begin
            gpr[dh] = k8;
        end else if ((w & 16'hF800) == 16'hB800) begin
            e.wr_count = 2'd1;
            e.wr_addr = {10'h0, w[10:9], w[3:0]} + avrx_pkg::IO_BASE;
            e.wr_d1 = gpr[d5];
        end else if (w == avrx_pkg::OP_SLEEP) begin
            e.run_status = avrx_pkg::RUN_SLEEP;
        end else if (w == avrx_pkg::OP_BREAK) begin
            e.run_status = avrx_pkg::RUN_BREAK;
        end else begin
            e.run_status = avrx_pkg::RUN_UNDEF;
            e.cycles = 3'd0;
            npc = pc;
        end
        pc = npc;
        total = total + e.cycles;
        e.next_pc = npc;
        e.flags = sreg;
        e.cycle_count = total;
        pending.push_back(e);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch in result %0d: %s got %h expected %h", checked, field, got, want);
    endtask

    task check_word(exec_result_t g);
        exec_result_t e;
        if (pending.size() == 0) begin
            errors++;
            $display("result word with nothing expected, next_pc %h", g.next_pc);
            return;
        end
        e = pending.pop_front();
        if (g.next_pc !== e.next_pc)
            report("next_pc", 32'(g.next_pc), 32'(e.next_pc));
        if (g.run_status !== e.run_status)
            report("run_status", 32'(g.run_status), 32'(e.run_status));
        if (g.cycles !== e.cycles)
            report("cycles_taken", 32'(g.cycles), 32'(e.cycles));
        if (g.wr_count !== e.wr_count)
            report("mem_write_count", 32'(g.wr_count), 32'(e.wr_count));
        if (g.wr_addr !== e.wr_addr)
            report("mem_write_addr", 32'(g.wr_addr), 32'(e.wr_addr));
        if (g.wr_d1 !== e.wr_d1)
            report("mem_write_first_data", 32'(g.wr_d1), 32'(e.wr_d1));
        if (g.wr_d2 !== e.wr_d2)
            report("mem_write_second_data", 32'(g.wr_d2), 32'(e.wr_d2));
        if (g.flags !== e.flags)
            report("flags_out", 32'(g.flags), 32'(e.flags));
        if (g.cycle_count !== e.cycle_count)
            report("cycle_count", g.cycle_count, e.cycle_count);
        checked++;
    endtask
endclass

module tb_avr_instruction_subset_execute;
    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_instr_word;
    logic [15:0] s_following_word;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_next_pc;
    logic [1:0]  m_run_status;
    logic [2:0]  m_cycles_taken;
    logic [1:0]  m_mem_write_count;
    logic [15:0] m_mem_write_addr;
    logic [7:0]  m_mem_write_first_data;
    logic [7:0]  m_mem_write_second_data;
    logic [7:0]  m_flags_out;
    logic [31:0] m_cycle_count;

    avr_exec_scoreboard exec_board;
    int words_sent;
    int op_hist [16];
    // While set, the result side holds m_ready low for a long stretch.
    logic stall_request;
    logic stall_running;

    avr_instruction_subset_execute u_dut (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .s_valid                 (s_valid),
        .s_ready                 (s_ready),
        .s_instr_word            (s_instr_word),
        .s_following_word        (s_following_word),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_next_pc               (m_next_pc),
        .m_run_status            (m_run_status),
        .m_cycles_taken          (m_cycles_taken),
        .m_mem_write_count       (m_mem_write_count),
        .m_mem_write_addr        (m_mem_write_addr),
        .m_mem_write_first_data  (m_mem_write_first_data),
        .m_mem_write_second_data (m_mem_write_second_data),
        .m_flags_out             (m_flags_out),
        .m_cycle_count           (m_cycle_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Safety net: the slowest legal run of about 1100 words with their random gaps
    // and the long hold-off stays far below this limit.
    initial begin
        #2000000;
        $display("timeout with %0d results still expected", exec_board.pending.size());
        $display("FAIL avr_instruction_subset_execute");
        $finish;
    end

    // Offers one word after a random gap, none if no_gap, holding it until taken.
    // The word is noted in the scoreboard at the accepting edge, so state
    // updates happen in the same order as in the block. Valid stays high
    // after acceptance until the next call decides on a gap.
    task send_word(logic [15:0] w, logic [15:0] w2, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_instr_word <= w;
        s_following_word <= w2;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        exec_board.note_word(w, w2);
        words_sent++;
        op_hist[w[15:12]]++;
        @(negedge aclk);
    endtask

    // Picks a word from the handled set most of the time and noise otherwise.
    function logic [15:0] pick_word();
        logic [15:0] r;
        r = 16'($urandom);
        case ($urandom_range(0, 21))
            0: return (r & 16'h03FF) | 16'h1C00;
            1: return (r & 16'h03FF) | 16'h0C00;
            2: return (r & 16'h00FF) | 16'h9600;
            3: return (r & 16'h03FF) | 16'h2000;
            4: return (r & 16'h0FFF) | 16'h7000;
            5: return (r & 16'h01F0) | 16'h9405;
            6: return (r & 16'h0070) | 16'h9488;
            7: return (r & 16'h01F7) | 16'hF800;
            8, 9: return (r & 16'h07FF) | 16'hF000;
            10: return (r & 16'h0070) | 16'h9408;
            11: return (r & 16'h01F7) | 16'hFA00;
            12: return (r & 16'h01F1) | 16'h940E;
            13: return (r & 16'h0FFF) | 16'h3000;
            14: return (r & 16'h03FF) | 16'h2400;
            15: return (r & 16'h01F0) | 16'h9403;
            16, 17: return (r & 16'h0FFF) | 16'hE000;
            18: return (r & 16'h07FF) | 16'hB800;
            19: return ($urandom_range(0, 1) != 0) ? avrx_pkg::OP_SLEEP : avrx_pkg::OP_BREAK;
            default: return r;
        endcase
    endfunction

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        int wait_cycles;
        exec_result_t got;
        m_ready = 1'b0;
        stall_running = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall_request && !stall_running) begin
                stall_running = 1'b1;
                m_ready <= 1'b0;
                repeat (60) @(negedge aclk);
                stall_running = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (wait_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got.next_pc = m_next_pc;
            got.run_status = m_run_status;
            got.cycles = m_cycles_taken;
            got.wr_count = m_mem_write_count;
            got.wr_addr = m_mem_write_addr;
            got.wr_d1 = m_mem_write_first_data;
            got.wr_d2 = m_mem_write_second_data;
            got.flags = m_flags_out;
            got.cycle_count = m_cycle_count;
            exec_board.check_word(got);
        end
    end

    initial begin
        int i;
        int guard;
        exec_board = new();
        words_sent = 0;
        stall_request = 1'b0;
        for (i = 0; i < 16; i++) op_hist[i] = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_instr_word = 16'h0000;
        s_following_word = 16'h0000;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes and each named corner case.
        send_word(16'hEFFF, 16'hFFFF, 0);  // LDI r31, 0xFF
        send_word(16'hEFEF, 16'h0000, 0);  // LDI r30, 0xFF
        send_word(16'h96FF, 16'h0000, 0);  // ADIW r31:r30, 63 carries out
        send_word(16'hE7AF, 16'h0000, 0);  // LDI r26, 0x7F
        send_word(16'h95A3, 16'h0000, 0);  // INC r26 overflows to 0x80
        send_word(16'h95A5, 16'h0000, 0);  // ASR r26 keeps the sign bit
        send_word(16'h0FAA, 16'h0000, 0);  // ADD r26, r26
        send_word(16'h1FFF, 16'h0000, 0);  // ADC r31, r31 with carry in
        send_word(16'h3F0F, 16'h0000, 0);  // CPI r16, 0xFF borrows
        send_word(16'h2000, 16'h0000, 0);  // AND r0, r0
        send_word(16'h7FFF, 16'h0000, 0);  // ANDI r31, 0xFF
        send_word(16'h27FF, 16'h0000, 0);  // EOR r31, r31
        send_word(16'h9468, 16'h0000, 0);  // BSET T
        send_word(16'hF9F7, 16'h0000, 0);  // BLD r31, 7
        send_word(16'hFBF7, 16'h0000, 0);  // BST r31, 7
        send_word(16'hBFFF, 16'h0000, 0);  // OUT 0x3F, r31
        send_word(16'hF3FE, 16'h0000, 0);  // BRBS T, -1
        send_word(16'hF40E, 16'h0000, 0);  // BRBC T, +1 not taken
        send_word(16'h95FF, 16'hFFFF, 0);  // CALL to 0xFFFF with ignored bits
        send_word(16'hF1FE, 16'h0000, 0);  // BRBS T, +63 wraps past the top
        send_word(16'h94F8, 16'h0000, 0);  // BCLR I
        send_word(avrx_pkg::OP_SLEEP, 16'h0000, 0);
        send_word(avrx_pkg::OP_BREAK, 16'h0000, 0);
        send_word(16'hFFFF, 16'hFFFF, 0);  // undefined

        // Pause until everything is back.
        s_valid <= 1'b0;
        while (exec_board.pending.size() != 0) @(negedge aclk);

        // Back-to-back words against a long result-side hold-off.
        stall_request = 1'b1;
        for (i = 0; i < 40; i++) send_word(pick_word(), 16'($urandom), 1);
        stall_request = 1'b0;

        for (i = 0; i < 1040; i++) begin
            if (i % 200 < 30) send_word(pick_word(), 16'($urandom), 1);
            else send_word(pick_word(), 16'($urandom), 0);
        end
        s_valid <= 1'b0;

        guard = 0;
        while (exec_board.pending.size() != 0 && guard < 20000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (20) @(negedge aclk);

        $display("%0d words sent, %0d results checked; upper opcode nibbles seen:",
                 words_sent, exec_board.checked);
        $display("  %p", op_hist);
        if (exec_board.errors == 0 && exec_board.pending.size() == 0) begin
            $display("PASS avr_instruction_subset_execute");
        end else begin
            $display("FAIL avr_instruction_subset_execute");
        end
        $finish;
    end
endmodule

`default_nettype wire
